[rtl/core/sgm_pkg.sv]
// shared types and constants for the sobel gradient magnitude block
// no dependencies; imported by sgm_lane, sgm_merge and the top level in rtl/core
package sgm_pkg;

  localparam int CH_W     = 8;             // one colour channel
  localparam int NUM_CH   = 3;             // blue, green, red
  localparam int RGB_W    = CH_W * NUM_CH; // packed pixel, blue in the low byte
  localparam int POS_W    = 11;            // reported row and column
  localparam int CFG_W    = 12;            // frame dimension registers
  localparam int GRAD_W   = 11;            // signed sobel sum, |g| <= 1020
  localparam int SQ_W     = 20;            // g*g < 2^20
  localparam int SUM_W    = SQ_W + 1;      // gx*gx + gy*gy
  localparam int ROOT_W   = 8;             // root bits, one per iteration
  localparam int SAT_BIT  = 2 * ROOT_W;    // sums at or above 2^16 saturate
  localparam int STEP_W   = $clog2(ROOT_W);

  localparam logic [CH_W-1:0]  MAG_MAX   = 8'd255;
  localparam logic [CFG_W-1:0] W_RESET   = 12'd640;
  localparam logic [CFG_W-1:0] H_RESET   = 12'd480;
  localparam int               DIM_MIN   = 3;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // per-lane step strobes from the sequencer
  typedef struct packed {
    logic              grad;     // capture gx, gy from the window
    logic              sqr;      // capture sum of squares, clear root
    logic              root;     // one bit of the root
    logic [STEP_W-1:0] step;     // which root bit, msb first
  } sgm_lane_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [CH_W-1:0]  mag_blue;
    logic [CH_W-1:0]  mag_green;
    logic [CH_W-1:0]  mag_red;
    logic             frame_end;
  } sgm_result_t;

endpackage

[rtl/core/sgm_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module sgm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[rtl/core/sgm_lane.sv]
// one colour lane: sobel sums, sum of squares, bit-serial clamped square root
// depends on sgm_pkg
module sgm_lane (
  input  logic                   clk,
  input  sgm_pkg::sgm_lane_ctl_t ctl,
  input  logic [7:0]             tl,
  input  logic [7:0]             tc,
  input  logic [7:0]             tr,
  input  logic [7:0]             ml,
  input  logic [7:0]             mr,
  input  logic [7:0]             bl,
  input  logic [7:0]             bc,
  input  logic [7:0]             br,
  output logic [7:0]             mag
);
  import sgm_pkg::*;

  logic signed [GRAD_W-1:0]   e_tl, e_tc, e_tr, e_ml, e_mr, e_bl, e_bc, e_br;
  logic signed [GRAD_W-1:0]   gx, gy;
  logic signed [GRAD_W-1:0]   gx_r, gy_r;
  logic signed [2*GRAD_W-1:0] sq_x, sq_y;
  logic [SUM_W-1:0]           sum;
  logic [SAT_BIT-1:0]         sum_r;
  logic                       sat_r;
  logic [ROOT_W-1:0]          root_r;
  logic [ROOT_W-1:0]          trial;
  logic [2*ROOT_W-1:0]        trial_sq;

  localparam logic [ROOT_W-1:0] ROOT_MSB = {1'b1, {(ROOT_W-1){1'b0}}};

  assign e_tl = $signed({{(GRAD_W-CH_W){1'b0}}, tl});
  assign e_tc = $signed({{(GRAD_W-CH_W){1'b0}}, tc});
  assign e_tr = $signed({{(GRAD_W-CH_W){1'b0}}, tr});
  assign e_ml = $signed({{(GRAD_W-CH_W){1'b0}}, ml});
  assign e_mr = $signed({{(GRAD_W-CH_W){1'b0}}, mr});
  assign e_bl = $signed({{(GRAD_W-CH_W){1'b0}}, bl});
  assign e_bc = $signed({{(GRAD_W-CH_W){1'b0}}, bc});
  assign e_br = $signed({{(GRAD_W-CH_W){1'b0}}, br});

  assign gx = (e_tr - e_tl) + ((e_mr - e_ml) <<< 1) + (e_br - e_bl);
  assign gy = (e_bl + (e_bc <<< 1) + e_br) - (e_tl + (e_tc <<< 1) + e_tr);

  assign sq_x = gx_r * gx_r;
  assign sq_y = gy_r * gy_r;
  assign sum  = {1'b0, sq_x[SQ_W-1:0]} + {1'b0, sq_y[SQ_W-1:0]};

  assign trial    = root_r | (ROOT_MSB >> ctl.step);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (ctl.grad) begin
      gx_r <= gx;
      gy_r <= gy;
    end
    if (ctl.sqr) begin
      sum_r  <= sum[SAT_BIT-1:0];
      sat_r  <= |sum[SUM_W-1:SAT_BIT];
      root_r <= '0;
    end else if (ctl.root) begin
      if (trial_sq <= sum_r) begin
        root_r <= trial;
      end
    end
  end

  assign mag = sat_r ? MAG_MAX : root_r;

endmodule

[rtl/core/sgm_merge.sv]
// merge stage: joins the lane magnitudes and position tag into one output register
// depends on sgm_pkg
module sgm_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sgm_pkg::sgm_result_t res,
  output logic                 can_load,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [10:0]          out_row,
  output logic [10:0]          out_col,
  output logic [7:0]           out_mag_blue,
  output logic [7:0]           out_mag_green,
  output logic [7:0]           out_mag_red,
  output logic                 out_frame_end
);
  import sgm_pkg::*;

  logic        valid_r;
  sgm_result_t data_r;

  assign can_load = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && can_load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data_r <= res;
    end
  end

  assign out_valid     = valid_r;
  assign out_row       = data_r.row;
  assign out_col       = data_r.col;
  assign out_mag_blue  = data_r.mag_blue;
  assign out_mag_green = data_r.mag_green;
  assign out_mag_red   = data_r.mag_red;
  assign out_frame_end = data_r.frame_end;

endmodule

[rtl/core/sobel_gradient_magnitude.sv]
// top level of the 3x3 sobel gradient magnitude block: config port, line stores,
// window, sequencer, three colour lanes and the merge stage
// depends on sgm_pkg, sgm_ram, sgm_lane, sgm_merge

// Pixels enter in raster order, one request per pixel, and each interior
// pixel (row r, col c) comes out tagged with r and c when pixel (r+1, c+1)
// arrives; border pixels produce nothing. A pixel that produces a result
// passes, from acceptance to the next acceptance, through the registered
// line store read, the sobel sums, the squares and the square root, which
// is worked out one bit per cycle in each of the three colour lanes side by
// side, then a hand-over to the output register. A pixel that produces
// nothing returns to idle after the line store read. The output
// register frees the input side, so a new pixel is taken while a result still
// waits; a stall on the output only holds the block once a second result is
// ready. Frame width and height live at byte addresses 0 and 4; writing
// either restarts the frame at row 0, column 0 and must be done while the
// block is idle. Values outside 3 to MAX_WIDTH (MAX_HEIGHT) are clamped.
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_row,
  output logic [10:0] out_col,
  output logic [7:0]  out_mag_blue,
  output logic [7:0]  out_mag_green,
  output logic [7:0]  out_mag_red,
  output logic        out_frame_end
);
  import sgm_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int EWW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int EHW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int CXW = (CW > POS_W) ? CW : POS_W;
  localparam int RXW = (RW > POS_W) ? RW : POS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r;

  logic [CFG_W-1:0]   img_w_r, img_h_r;
  logic [EWW-1:0]     w_ext, w_eff, w_last_full;
  logic [EHW-1:0]     h_ext, h_eff, h_last_full;
  logic [CW-1:0]      last_col;
  logic [RW-1:0]      last_row;

  logic [CW-1:0]      col_cnt_r;
  logic [RW-1:0]      row_cnt_r;

  logic               cfg_wr;
  logic               in_acc;
  logic               emit_now;
  logic [CXW-1:0]     col_m1;
  logic [RXW-1:0]     row_m1;

  // captured request
  logic [RGB_W-1:0]   px_r;
  logic [CW-1:0]      wcol_r;
  logic               emit_r;
  logic [POS_W-1:0]   pos_row_r, pos_col_r;
  logic               fend_r;

  // line stores and window
  logic [RGB_W-1:0]   above_rd, two_above_rd;
  logic [RGB_W-1:0]   win_r [6];
  logic [RGB_W-1:0]   win [9];
  logic               line_we;

  sgm_lane_ctl_t      lane_ctl;
  logic [CH_W-1:0]    mag [NUM_CH];
  sgm_result_t        res;
  logic               can_load;
  logic               load;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= W_RESET;
      img_h_r <= H_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH:  img_w_r <= pwdata[CFG_W-1:0];
        REG_HEIGHT: img_h_r <= pwdata[CFG_W-1:0];
        default:    img_w_r <= img_w_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, img_w_r};
      REG_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, img_h_r};
      default:    prdata = '0;
    endcase
  end

  // effective frame size, clamped to 3..max
  always_comb begin
    w_ext = EWW'(img_w_r);
    if (w_ext < EWW'(DIM_MIN)) begin
      w_eff = EWW'(DIM_MIN);
    end else if (w_ext > EWW'(MAX_WIDTH)) begin
      w_eff = EWW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_ext = EHW'(img_h_r);
    if (h_ext < EHW'(DIM_MIN)) begin
      h_eff = EHW'(DIM_MIN);
    end else if (h_ext > EHW'(MAX_HEIGHT)) begin
      h_eff = EHW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    w_last_full = w_eff - EWW'(1);
    h_last_full = h_eff - EHW'(1);
  end

  assign last_col = w_last_full[CW-1:0];
  assign last_row = h_last_full[RW-1:0];

  // ---------------------------------------------------------------- input side
  // one pixel in flight; the line store read issues at the accepting edge
  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign in_acc   = in_valid && !in_stall;

  // interior pixel one up and one left is complete once this pixel arrives
  assign emit_now = (row_cnt_r >= RW'(2)) && (col_cnt_r >= CW'(2));
  assign col_m1   = CXW'(col_cnt_r) - CXW'(1);
  assign row_m1   = RXW'(row_cnt_r) - RXW'(1);

  // raster position of the next pixel; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      if (col_cnt_r == last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_cnt_r == last_row) ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r      <= {in_red, in_green, in_blue};
      wcol_r    <= col_cnt_r;
      emit_r    <= emit_now;
      pos_row_r <= row_m1[POS_W-1:0];
      pos_col_r <= col_m1[POS_W-1:0];
      fend_r    <= (row_cnt_r == last_row) && (col_cnt_r == last_col);
    end
  end

  // ---------------------------------------------------------------- line stores
  // read at the current column, written back in the cycle after
  assign line_we = (state_r == S_READ);

  sgm_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_above (
    .clk   (clk),
    .we    (line_we),
    .waddr (wcol_r),
    .wdata (px_r),
    .raddr (col_cnt_r),
    .rdata (above_rd)
  );

  sgm_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_two_above (
    .clk   (clk),
    .we    (line_we),
    .waddr (wcol_r),
    .wdata (above_rd),
    .raddr (col_cnt_r),
    .rdata (two_above_rd)
  );

  // ---------------------------------------------------------------- window
  // entries 0..2 column c-2, 3..5 column c-1, 6..8 column c; top, mid, bottom
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win[i] = win_r[i];
    end
    win[6] = two_above_rd;
    win[7] = above_rd;
    win[8] = px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (state_r == S_READ) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= win[i + 3];
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_READ;
      S_READ: state_nxt = emit_r ? S_SQR : S_IDLE;
      S_SQR:  state_nxt = S_ROOT;
      S_ROOT: if (step_r == STEP_W'(ROOT_W - 1)) state_nxt = S_DONE;
      S_DONE: if (can_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SQR) begin
        step_r <= '0;
      end else if (state_r == S_ROOT) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  assign lane_ctl.grad = (state_r == S_READ);
  assign lane_ctl.sqr  = (state_r == S_SQR);
  assign lane_ctl.root = (state_r == S_ROOT);
  assign lane_ctl.step = step_r;

  // ---------------------------------------------------------------- lanes
  // lane 0 blue, lane 1 green, lane 2 red
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    sgm_lane u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .tl  (win[0][g*CH_W +: CH_W]),
      .ml  (win[1][g*CH_W +: CH_W]),
      .bl  (win[2][g*CH_W +: CH_W]),
      .tc  (win[3][g*CH_W +: CH_W]),
      .bc  (win[5][g*CH_W +: CH_W]),
      .tr  (win[6][g*CH_W +: CH_W]),
      .mr  (win[7][g*CH_W +: CH_W]),
      .br  (win[8][g*CH_W +: CH_W]),
      .mag (mag[g])
    );
  end

  // ---------------------------------------------------------------- merge
  assign res.row       = pos_row_r;
  assign res.col       = pos_col_r;
  assign res.mag_blue  = mag[0];
  assign res.mag_green = mag[1];
  assign res.mag_red   = mag[2];
  assign res.frame_end = fend_r;
  assign load          = (state_r == S_DONE);

  sgm_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .res           (res),
    .can_load      (can_load),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_mag_blue  (out_mag_blue),
    .out_mag_green (out_mag_green),
    .out_mag_red   (out_mag_red),
    .out_frame_end (out_frame_end)
  );

  // ---------------------------------------------------------------- checks
  // an interior pixel's request leads through the read, square and root states to the hand-over state
  a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit_now) |-> ##11 (state_r == S_DONE))
    else $error("interior result not ready on time");

  // position counters stay inside the effective frame
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_cnt_r <= last_col) && (row_cnt_r <= last_row))
    else $error("raster position outside frame");

  // a new result only appears out of the hand-over state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished pixel");

endmodule
